// ===== sv/gpt_pkg.sv =====
// gpt_pkg: widths, codes, packed types and helpers of the game port timer
// used by every module of the block; depends on nothing

package gpt_pkg;

   localparam int FULL_W   = 24;
   localparam int POS_W    = 16;
   localparam int DATA_W   = 8;
   localparam int ACT_W    = 2;
   localparam int KEY_W    = 40;
   localparam int REQ_W    = 48;
   localparam int CSR_IDX_W = 1;

   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 31;
   localparam int PROD_W      = FULL_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;

   localparam logic [FULL_W-1:0] FULL_RESET = 24'd7000;
   localparam logic [FULL_W-1:0] TICK_MAX   = {FULL_W{1'b1}};
   localparam logic [KEY_W-1:0]  KEY_STEP   = 40'd65535;

   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TRIG = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANALOG_MODE = 1'd1;

   localparam logic [DATA_W-1:0] RAPID_MASK  = 8'h30;
   localparam logic [DATA_W-1:0] TRIG_MASK   = 8'hc0;
   localparam logic [DATA_W-1:0] AXIS_MASK   = 8'h0f;
   localparam logic [DATA_W-1:0] X_BIT       = 8'h01;
   localparam logic [DATA_W-1:0] Y_BIT       = 8'h02;
   localparam logic [DATA_W-1:0] ABSENT_BYTE = 8'hff;

   typedef struct packed {
      logic              analog;
      logic [FULL_W-1:0] margin;
      logic [FULL_W-1:0] half;
      logic [FULL_W-1:0] full_minus_m;
      logic [FULL_W-1:0] span;
      logic [KEY_W-1:0]  margin_key;
   } cfg_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [DATA_W-1:0] status;
      logic              present;
      logic [KEY_W-1:0]  key_x;
      logic [KEY_W-1:0]  key_y;
   } item_type;

   function automatic logic [DATA_W-1:0] buttons_of(input logic [DATA_W-1:0] s);
      return ((s >> 2) & RAPID_MASK) | ((s << 2) & TRIG_MASK);
   endfunction

endpackage

// ===== sv/gpt_csr.sv =====
// gpt_csr: configuration registers and the derived axis thresholds
// depends on gpt_pkg

module gpt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [gpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gpt_pkg::FULL_W-1:0]    csr_wdata,
   output gpt_pkg::cfg_type              cfg,
   output logic                          busy
);
   import gpt_pkg::*;

   logic [FULL_W-1:0]   full_ff;
   logic                analog_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [FULL_W-1:0]   margin_ff;
   logic [FULL_W-1:0]   margin_d_ff;
   logic [FULL_W-1:0]   half_ff;
   logic [FULL_W-1:0]   full_minus_m_ff;
   logic [FULL_W-1:0]   span_ff;
   logic [KEY_W-1:0]    margin_key_ff;
   logic [SETTLE_W-1:0] settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff   <= FULL_RESET;
         analog_ff <= 1'b0;
         settle_ff <= SETTLE_CYCLES;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_FULL_SCALE:  full_ff   <= csr_wdata;
               REG_ANALOG_MODE: analog_ff <= csr_wdata[0];
               default: ;
            endcase
            settle_ff <= SETTLE_CYCLES;
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - SETTLE_W'(1);
         end
      end
   end

   // margin = full / 100 by reciprocal multiply
   always_ff @(posedge clock) begin
      prod_ff         <= PROD_W'(full_ff) * PROD_W'(RECIP_100);
      margin_ff       <= FULL_W'(prod_ff >> RECIP_SHIFT);
      margin_d_ff     <= margin_ff;
      half_ff         <= full_ff >> 1;
      full_minus_m_ff <= full_ff - margin_ff;
      span_ff         <= full_ff - (margin_ff << 1);
      margin_key_ff   <= (KEY_W'(margin_ff) << POS_W) - KEY_W'(margin_ff);
   end

   always_comb begin
      cfg.analog       = analog_ff;
      cfg.margin       = margin_d_ff;
      cfg.half         = half_ff;
      cfg.full_minus_m = full_minus_m_ff;
      cfg.span         = span_ff;
      cfg.margin_key   = margin_key_ff;
   end

   assign busy = settle_ff != '0;

endmodule

// ===== sv/gpt_front.sv =====
// gpt_front: accepts request beats and scales the analog positions
// depends on gpt_pkg; feeds gpt_fifo

module gpt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [gpt_pkg::ACT_W-1:0]  req_tuser,
   input  logic [gpt_pkg::REQ_W-1:0]  req_tdata,
   input  gpt_pkg::cfg_type           cfg,
   input  logic                       busy,
   input  logic                       fifo_full,
   output logic                       push,
   output gpt_pkg::item_type          push_item
);
   import gpt_pkg::*;

   logic              valid_ff, valid_in;
   item_type          item_ff, item_in;
   logic              accept;
   logic [POS_W-1:0]  pos_x, pos_y;

   assign pos_x      = req_tdata[24:9];
   assign pos_y      = req_tdata[40:25];
   assign push       = valid_ff && !fifo_full;
   assign req_tready = !busy && (!valid_ff || !fifo_full);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in.action  = req_tuser;
      item_in.status  = req_tdata[7:0];
      item_in.present = req_tdata[8];
      item_in.key_x   = KEY_W'(cfg.span) * KEY_W'(pos_x) + cfg.margin_key;
      item_in.key_y   = KEY_W'(cfg.span) * KEY_W'(pos_y) + cfg.margin_key;
      valid_in        = accept ? 1'b1 : (push ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_item = item_ff;

endmodule

// ===== sv/gpt_fifo.sv =====
// gpt_fifo: short queue of classified items between front and back
// depends on gpt_pkg

module gpt_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gpt_pkg::item_type push_item,
   input  logic              pop,
   output gpt_pkg::item_type head,
   output logic              full,
   output logic              empty
);
   import gpt_pkg::*;

   item_type         mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full  = count_ff == (PTR_W + 1)'(FIFO_DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PTR_W + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/gpt_back.sv =====
// gpt_back: tick counter, port flags and axis one-shots, plus result register
// depends on gpt_pkg; drains gpt_fifo

module gpt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gpt_pkg::cfg_type           cfg,
   input  gpt_pkg::item_type          head,
   input  logic                       empty,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [gpt_pkg::DATA_W-1:0] rsp_tdata
);
   import gpt_pkg::*;

   logic [FULL_W-1:0] elapsed_ff, elapsed_in;
   logic [KEY_W-1:0]  ekey_ff, ekey_in;
   logic [DATA_W-1:0] flags_ff, flags_in;
   logic [DATA_W-1:0] dir_ff, dir_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, result;
   logic [DATA_W-1:0] fresh;
   logic [FULL_W-1:0] tx, ty;
   logic              hit_x, hit_y;

   assign pop = !empty && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      tx = cfg.half;
      ty = cfg.half;
      if (!dir_ff[0]) ty = cfg.margin;
      if (!dir_ff[1]) ty = cfg.full_minus_m;
      if (!dir_ff[2]) tx = cfg.margin;
      if (!dir_ff[3]) tx = cfg.full_minus_m;
      hit_x = cfg.analog ? (head.key_x < ekey_ff) : (elapsed_ff >= tx);
      hit_y = cfg.analog ? (head.key_y < ekey_ff) : (elapsed_ff >= ty);
      fresh = buttons_of(head.status) | (flags_ff & AXIS_MASK);
   end

   always_comb begin
      elapsed_in = elapsed_ff;
      ekey_in    = ekey_ff;
      flags_in   = flags_ff;
      dir_in     = dir_ff;
      result     = '0;
      if (pop) begin
         unique case (head.action)
            ACT_TICK: begin
               if (elapsed_ff != TICK_MAX) begin
                  elapsed_in = elapsed_ff + FULL_W'(1);
                  ekey_in    = ekey_ff + KEY_STEP;
               end
            end
            ACT_TRIG: begin
               if (head.present) begin
                  dir_in     = head.status;
                  flags_in   = buttons_of(head.status) | AXIS_MASK;
                  elapsed_in = '0;
                  ekey_in    = KEY_STEP;
               end
            end
            ACT_READ: begin
               flags_in = fresh;
               if (!head.present) begin
                  result = ABSENT_BYTE;
               end else begin
                  result   = fresh;
                  flags_in = fresh & ~(hit_x ? X_BIT : '0) & ~(hit_y ? Y_BIT : '0);
               end
            end
            default: ;
         endcase
      end
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         ekey_ff      <= KEY_STEP;
         flags_ff     <= '0;
         dir_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         elapsed_ff   <= elapsed_in;
         ekey_ff      <= ekey_in;
         flags_ff     <= flags_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // compare key tracks (elapsed + 1) scaled by full deflection
   a_key_tracks: assert property (@(posedge clock) disable iff (reset)
      ekey_ff == (KEY_W'(elapsed_ff) + KEY_W'(1)) * KEY_STEP)
      else $error("compare key out of step with tick counter");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      pop && head.action == ACT_TICK && elapsed_ff != TICK_MAX
      |=> elapsed_ff == $past(elapsed_ff) + FULL_W'(1))
      else $error("tick beat did not advance counter");

   a_trig_clears: assert property (@(posedge clock) disable iff (reset)
      pop && head.action == ACT_TRIG && head.present
      |=> elapsed_ff == '0 && flags_ff[3:0] == 4'hf)
      else $error("trigger did not restart the one-shots");

   a_read_keeps_upper: assert property (@(posedge clock) disable iff (reset)
      pop && head.action == ACT_READ
      |=> flags_ff[3:2] == $past(flags_ff[3:2]))
      else $error("read touched bits 2 and 3");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !pop)
      else $error("item executed into a stalled result slot");

endmodule

// ===== sv/gameport_one_shot_axis_timer.sv =====
// gameport_one_shot_axis_timer: joystick game port with one-shot axis timers
// depends on gpt_pkg, gpt_csr, gpt_front, gpt_fifo, gpt_back
//
// channel   dir  beat fields
// req_*     in   tuser: action; tdata: joy_status, joy_present, analog_x, analog_y
// rsp_*     out  tdata: read_data
// csr_*     in   write of full_scale_ticks (index 0) or analog_mode (index 1)
//
// one beat per cycle sustained while rsp is ready and no csr settle is pending;
// a beat reaches rsp through the front register (position multiply), the queue
// and the result register (execute). req_tready stays low after reset and after
// each csr write while the margin (full / 100) and thresholds are recomputed.
// a stalled rsp fills the result register, then the two-entry queue, then the
// front register before req_tready drops.

module gameport_one_shot_axis_timer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gpt_pkg::ACT_W-1:0]     req_tuser,  // action
   // joy_status, joy_present, analog_x, analog_y, zero pad
   input  logic [gpt_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gpt_pkg::DATA_W-1:0]    rsp_tdata,  // read_data
   input  logic                          csr_we,
   input  logic [gpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gpt_pkg::FULL_W-1:0]    csr_wdata
);
   import gpt_pkg::*;

   cfg_type  cfg;
   logic     busy;
   logic     push, pop, fifo_full, fifo_empty;
   item_type push_item, head;

   gpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (busy)
   );

   gpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .busy       (busy),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_item  (push_item)
   );

   gpt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   gpt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .empty      (fifo_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for gameport_one_shot_axis_timer, beat-level predictor
// of the axis one-shots and button flags; depends on gpt_pkg and the block rtl

module tb;
   import gpt_pkg::*;

   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ACT_W-1:0]     req_tuser = ACT_TICK;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_FULL_SCALE;
   logic [FULL_W-1:0]    csr_wdata = '0;

   // predictor state
   logic [FULL_W-1:0] pred_full;
   logic              pred_analog;
   logic [FULL_W-1:0] tick_count;
   logic [DATA_W-1:0] flag_byte;
   logic [DATA_W-1:0] dir_latch;

   logic [DATA_W-1:0] expected_bytes[$];
   logic [DATA_W-1:0] want_byte;
   int                fails = 0;
   bit                idle_tx = 1'b0;
   bit                idle_rx = 1'b0;
   int                rx_hold = 0;

   gameport_one_shot_axis_timer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [FULL_W-1:0] axis_limit(input logic [FULL_W-1:0] full,
                                                   input logic [FULL_W-1:0] m,
                                                   input logic [POS_W-1:0] pos);
      logic [63:0] span;
      logic [63:0] scaled;
      span = 64'(full) - 64'(m) * 64'd2;
      scaled = (span * 64'(pos)) / 64'd65535;
      return m + scaled[FULL_W-1:0];
   endfunction

   // advances the predictor by one accepted beat and returns its read byte
   function automatic logic [DATA_W-1:0] predict_port_byte(input logic [ACT_W-1:0] act,
                                                          input logic [DATA_W-1:0] st,
                                                          input logic pr,
                                                          input logic [POS_W-1:0] x,
                                                          input logic [POS_W-1:0] y);
      logic [DATA_W-1:0] btn;
      logic [DATA_W-1:0] res;
      logic [FULL_W-1:0] m;
      logic [FULL_W-1:0] lim_x;
      logic [FULL_W-1:0] lim_y;
      btn = {st[5:4], st[7:6], 4'b0000};
      res = '0;
      m = pred_full / 24'd100;
      case (act)
         ACT_TICK: begin
            if (tick_count != TICK_MAX) tick_count = tick_count + 1'b1;
         end
         ACT_TRIG: begin
            if (pr) begin
               dir_latch = st;
               flag_byte = btn | AXIS_MASK;
               tick_count = '0;
            end
         end
         ACT_READ: begin
            flag_byte = btn | (flag_byte & AXIS_MASK);
            if (!pr) begin
               res = ABSENT_BYTE;
            end else begin
               if (pred_analog) begin
                  lim_x = axis_limit(pred_full, m, x);
                  lim_y = axis_limit(pred_full, m, y);
               end else begin
                  lim_x = pred_full / 24'd2;
                  lim_y = pred_full / 24'd2;
                  if (!dir_latch[0]) lim_y = m;
                  if (!dir_latch[1]) lim_y = pred_full - m;
                  if (!dir_latch[2]) lim_x = m;
                  if (!dir_latch[3]) lim_x = pred_full - m;
               end
               res = flag_byte;
               if (tick_count >= lim_x) flag_byte = flag_byte & ~X_BIT;
               if (tick_count >= lim_y) flag_byte = flag_byte & ~Y_BIT;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] st,
                            input logic pr, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y);
      int gap;
      gap = idle_tx ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= act;
      req_tdata <= {7'b0, y, x, pr, st};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_bytes.push_back(predict_port_byte(act, st, pr, x, y));
   endtask

   task automatic send_random_read(input logic pr);
      send_item(ACT_READ, 8'($urandom), pr, 16'($urandom), 16'($urandom));
   endtask

   // full scale first, then the mode word; only with no beat in flight
   task automatic write_config(input logic [FULL_W-1:0] full, input logic [FULL_W-1:0] mode);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_FULL_SCALE;
      csr_wdata <= full;
      @(posedge clock);
      pred_full = full;
      csr_index <= REG_ANALOG_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      pred_analog = mode[0];
      csr_we <= 1'b0;
   endtask

   task automatic test_directed();
      write_config(FULL_RESET, 24'd0);
      send_item(ACT_SPARE, 8'h00, 1'b1, 16'hffff, 16'hffff);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 16'h0000);
      send_item(ACT_TRIG, 8'h00, 1'b0, 16'h0000, 16'h0000);
      send_item(ACT_TRIG, 8'hf0, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_TICK, 8'hff, 1'b1, 16'hffff, 16'hffff);
      send_item(ACT_READ, 8'hff, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_READ, 8'h00, 1'b1, 16'hffff, 16'hffff);
      // zero full scale: both thresholds at zero
      write_config(24'd0, 24'd0);
      send_item(ACT_TRIG, 8'h00, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_READ, 8'h0f, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_READ, 8'hf0, 1'b1, 16'h0000, 16'h0000);
      // full scale below 100 so the margin is zero, analog with noise in the upper mode bits
      write_config(24'd50, 24'hfffffe | 24'd1);
      send_item(ACT_TRIG, 8'h5a, 1'b1, 16'h0000, 16'h0000);
      repeat (3) send_item(ACT_TICK, 8'ha5, 1'b0, 16'h1234, 16'h4321);
      send_item(ACT_READ, 8'h5a, 1'b1, 16'hffff, 16'h0000);
      send_item(ACT_READ, 8'h5a, 1'b1, 16'h0000, 16'hffff);
      write_config(24'd100, 24'd1);
      send_item(ACT_TRIG, 8'hff, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_TICK, 8'h00, 1'b0, 16'h0000, 16'h0000);
      send_item(ACT_READ, 8'hff, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_READ, 8'hff, 1'b0, 16'hffff, 16'hffff);
      send_item(ACT_READ, 8'hff, 1'b1, 16'h0000, 16'h0000);
   endtask

   task automatic test_full_scale_max();
      write_config(TICK_MAX, 24'd1);
      send_item(ACT_TRIG, 8'h00, 1'b1, 16'h0000, 16'h0000);
      repeat (4) send_item(ACT_TICK, 8'h00, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_READ, 8'h33, 1'b1, 16'h0000, 16'hffff);
      write_config(TICK_MAX, 24'd0);
      send_item(ACT_TRIG, 8'ha5, 1'b1, 16'h0000, 16'h0000);
      send_item(ACT_READ, 8'hcc, 1'b1, 16'h0000, 16'h0000);
   endtask

   // receiver stops for a long stretch while beats keep coming
   task automatic test_backpressure();
      write_config(24'd120, 24'd0);
      idle_tx = 1'b0;
      idle_rx = 1'b0;
      rx_hold = 60;
      send_item(ACT_TRIG, 8'($urandom), 1'b1, 16'h0000, 16'h0000);
      repeat (40) begin
         if ($urandom_range(0, 3) == 0) send_random_read(1'b1);
         else send_item(ACT_TICK, 8'($urandom), 1'b1, 16'($urandom), 16'($urandom));
      end
   endtask

   // trigger, a run of ticks with reads sprinkled in, and some noise
   task automatic run_sessions(input int count);
      int n;
      int len;
      int pick;
      n = 0;
      while (n < count) begin
         send_item(ACT_TRIG, 8'($urandom), 1'b1, 16'($urandom), 16'($urandom));
         len = $urandom_range(1, int'(pred_full) + int'(pred_full) / 8 + 4);
         if (len > 400) len = $urandom_range(1, 400);
         n = n + len + 1;
         repeat (len) begin
            pick = $urandom_range(0, 15);
            if (pick <= 10) begin
               send_item(ACT_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick <= 13) begin
               send_random_read(1'b1);
            end else if (pick == 14) begin
               send_random_read(1'b0);
            end else begin
               send_item(2'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
                         16'($urandom));
            end
         end
      end
   endtask

   task automatic test_random_sessions();
      int mode_sel;
      for (int p = 0; p < 8; p++) begin
         write_config(24'($urandom_range(100, 300)), 24'($urandom));
         mode_sel = $urandom_range(0, 3);
         idle_tx = mode_sel[0];
         idle_rx = mode_sel[1];
         run_sessions(150);
      end
      write_config(24'($urandom), 24'($urandom));
      idle_tx = 1'b1;
      idle_rx = 1'b1;
      run_sessions(30);
   endtask

   // receiver
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold) @(posedge clock);
            rx_hold = 0;
         end
         gap = idle_rx ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("read_data: expected none actual %h", rsp_tdata);
            fails++;
         end else begin
            want_byte = expected_bytes.pop_front();
            if (rsp_tdata !== want_byte) begin
               $error("read_data: expected %h actual %h", want_byte, rsp_tdata);
               fails++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("gameport_one_shot_axis_timer: mismatch");
      $finish;
   end

   initial begin
      pred_full = FULL_RESET;
      pred_analog = 1'b0;
      tick_count = '0;
      flag_byte = '0;
      dir_latch = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      idle_tx = 1'b1;
      idle_rx = 1'b1;
      test_directed();
      test_full_scale_max();
      test_backpressure();
      test_random_sessions();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("gameport_one_shot_axis_timer: match");
      end else begin
         $display("gameport_one_shot_axis_timer: mismatch");
      end
      $finish;
   end

endmodule

// ===== gameport_one_shot_axis_timer.f =====
sv/gpt_pkg.sv
sv/gpt_csr.sv
sv/gpt_front.sv
sv/gpt_fifo.sv
sv/gpt_back.sv
sv/gameport_one_shot_axis_timer.sv
verif/tb.sv
